### hw/rtl/mlpq_pkg.sv
package mlpq_pkg;

    localparam int MAX_LEVELS_DEF  = 4;
    localparam int LEVEL_DEPTH_DEF = 16;
    localparam int VALUE_W         = 32;
    localparam int LEVEL_IN_W      = 3;
    localparam int LEVEL_OUT_W     = 2;
    localparam int CFG_LEVELS_W    = 3;
    localparam int NUM_LEVELS_W    = CFG_LEVELS_W + 1;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 3;

    localparam logic [CFG_LEVELS_W-1:0] LEVELS_RESET = CFG_LEVELS_W'(4);

    typedef enum logic {
        REG_LEVELS_IN_USE = 1'b0,
        REG_UNUSED        = 1'b1
    } t_reg_idx;

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

endpackage

### hw/rtl/multi_level_priority_queue.sv
// Strict-priority queue with one FIFO of LEVEL_DEPTH words per level, up to MAX_LEVELS levels.
// An enqueue appends i_value to the FIFO of i_level when that level is below levels_in_use
// (capped at MAX_LEVELS) and the FIFO is not full. A dequeue pops the head of the
// lowest-numbered non-empty level in use. Every input transfer yields exactly one result
// transfer: o_status is ok, level out of range, queue empty or level full, and o_out_value /
// o_out_level are zero unless a dequeue succeeds. One item is taken per clock unless results
// stall. An input transfer reads the entry RAM and loads the stage-1 registers; the output
// register loads from them when free. Words in levels above a lowered levels_in_use are kept
// and become visible again when the count is raised. levels_in_use sits at APB byte address 0,
// resets to 4. The user writes it only while the queue is idle; the block does not enforce it.
module multi_level_priority_queue #(
    parameter int MAX_LEVELS  = mlpq_pkg::MAX_LEVELS_DEF,
    parameter int LEVEL_DEPTH = mlpq_pkg::LEVEL_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_operation,
    input  logic signed [mlpq_pkg::VALUE_W-1:0]  i_value,
    input  logic [mlpq_pkg::LEVEL_IN_W-1:0]      i_level,

    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [1:0]                           o_status,
    output logic signed [mlpq_pkg::VALUE_W-1:0]  o_out_value,
    output logic [mlpq_pkg::LEVEL_OUT_W-1:0]     o_out_level,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mlpq_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [mlpq_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [mlpq_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    import mlpq_pkg::*;

    localparam int LVL_W     = $clog2(MAX_LEVELS);
    localparam int IDX_W     = $clog2(LEVEL_DEPTH);
    localparam int CNT_W     = $clog2(LEVEL_DEPTH + 1);
    localparam int RAM_DEPTH = MAX_LEVELS * (2 ** IDX_W);
    localparam int ADDR_W    = $clog2(RAM_DEPTH);

    localparam logic [IDX_W-1:0]        IDX_LAST = IDX_W'(LEVEL_DEPTH - 1);
    localparam logic [CNT_W-1:0]        CNT_FULL = CNT_W'(LEVEL_DEPTH);
    localparam logic [NUM_LEVELS_W-1:0] N_MAX    = NUM_LEVELS_W'(MAX_LEVELS);

    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
        return (idx == IDX_LAST) ? '0 : idx + IDX_W'(1);
    endfunction

    function automatic logic found_ok_dequeue(input t_status st, input logic is_deq);
        return (st == ST_OK) && is_deq;
    endfunction

    logic [CFG_LEVELS_W-1:0] r_levels;
    logic [IDX_W-1:0]        r_head  [MAX_LEVELS];
    logic [IDX_W-1:0]        r_tail  [MAX_LEVELS];
    logic [CNT_W-1:0]        r_count [MAX_LEVELS];
    logic [IDX_W-1:0]        n_head  [MAX_LEVELS];
    logic [IDX_W-1:0]        n_tail  [MAX_LEVELS];
    logic [CNT_W-1:0]        n_count [MAX_LEVELS];

    logic                    r_s1_valid;
    t_status                 r_s1_status;
    logic [LVL_W-1:0]        r_s1_level;
    logic                    r_s1_deq;

    logic                    r_out_valid;
    t_status                 r_out_status;
    logic signed [VALUE_W-1:0] r_out_value;
    logic [LEVEL_OUT_W-1:0]  r_out_level;

    logic                    in_xfer;
    logic                    s1_advance;
    logic [NUM_LEVELS_W-1:0] eff_levels;
    logic [LVL_W-1:0]        enq_lvl;
    logic                    in_range;
    logic                    enq_full;
    logic                    found;
    logic [LVL_W-1:0]        deq_lvl;
    t_status                 n_status;
    logic                    enq_do;
    logic                    deq_do;
    logic [ADDR_W-1:0]       waddr;
    logic [ADDR_W-1:0]       raddr;
    logic [VALUE_W-1:0]      ram_rdata;
    logic                    cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (t_reg_idx'(paddr[2]) == REG_LEVELS_IN_USE);
    assign prdata    = (t_reg_idx'(paddr[2]) == REG_LEVELS_IN_USE)
                     ? {{(APB_DATA_W - CFG_LEVELS_W){1'b0}}, r_levels} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= LEVELS_RESET;
        end else if (cfg_write) begin
            r_levels <= pwdata[CFG_LEVELS_W-1:0];
        end
    end

    assign s1_advance = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s1_advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_comb begin
        eff_levels = ({1'b0, r_levels} > N_MAX) ? N_MAX : {1'b0, r_levels};
        enq_lvl    = i_level[LVL_W-1:0];
        in_range   = {1'b0, i_level} < eff_levels;
        enq_full   = r_count[enq_lvl] == CNT_FULL;
        found      = 1'b0;
        deq_lvl    = '0;
        for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
            if ((NUM_LEVELS_W'(i) < eff_levels) && (r_count[i] != '0)) begin
                found   = 1'b1;
                deq_lvl = LVL_W'(i);
            end
        end
        if (t_op'(i_operation) == OP_ENQUEUE) begin
            if (!in_range) begin
                n_status = ST_RANGE;
            end else if (enq_full) begin
                n_status = ST_FULL;
            end else begin
                n_status = ST_OK;
            end
        end else begin
            n_status = found ? ST_OK : ST_EMPTY;
        end
        enq_do = in_xfer && (t_op'(i_operation) == OP_ENQUEUE) && in_range && !enq_full;
        deq_do = in_xfer && (t_op'(i_operation) == OP_DEQUEUE) && found;
        waddr  = {enq_lvl, r_tail[enq_lvl]};
        raddr  = {deq_lvl, r_head[deq_lvl]};
    end

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (enq_do) begin
            n_tail[enq_lvl]  = advance(r_tail[enq_lvl]);
            n_count[enq_lvl] = r_count[enq_lvl] + CNT_W'(1);
        end
        if (deq_do) begin
            n_head[deq_lvl]  = advance(r_head[deq_lvl]);
            n_count[deq_lvl] = r_count[deq_lvl] - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    mlpq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (enq_do),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_re    (deq_do),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_status <= n_status;
            r_s1_level  <= deq_lvl;
            r_s1_deq    <= t_op'(i_operation) == OP_DEQUEUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && r_s1_valid) begin
            r_out_status <= r_s1_status;
            if (found_ok_dequeue(r_s1_status, r_s1_deq)) begin
                r_out_value <= $signed(ram_rdata);
                r_out_level <= LEVEL_OUT_W'(r_s1_level);
            end else begin
                r_out_value <= '0;
                r_out_level <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_out_value = r_out_value;
    assign o_out_level = r_out_level;

endmodule

### hw/rtl/mlpq_ram.sv
module mlpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/mlpq_checker.sv
module mlpq_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic [1:0]                           o_status,
    input logic signed [mlpq_pkg::VALUE_W-1:0]  o_out_value,
    input logic [mlpq_pkg::LEVEL_OUT_W-1:0]     o_out_level,
    input logic                                 psel,
    input logic                                 penable,
    input logic                                 pready
);

    import mlpq_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_out_value) && $stable(o_out_level))
        else $error("result changed while stalled");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_out_value == '0) && (o_out_level == '0))
        else $error("rejected item carries a payload");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_first_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n, 2) && $past(!i_rst_n, 3) |-> !o_out_valid)
        else $error("result before any transfer");

    a_pready: assert property (@(posedge i_clk) psel && penable |-> pready)
        else $error("APB access stalled");

endmodule

bind multi_level_priority_queue mlpq_checker u_mlpq_checker (.*);

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mlpq_pkg::*;

    localparam int NUM_LEVELS  = MAX_LEVELS_DEF;
    localparam int FIFO_DEPTH  = LEVEL_DEPTH_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int SEG_ITEMS   = 100;
    localparam int SEG_COUNT   = 5;

    typedef struct packed {
        t_op                       op;
        logic signed [VALUE_W-1:0] value;
        logic [LEVEL_IN_W-1:0]     level;
    } t_pq_cmd;

    typedef struct packed {
        t_status                   status;
        logic signed [VALUE_W-1:0] value;
        logic [LEVEL_OUT_W-1:0]    level;
    } t_pq_result;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_ready;
    logic                      i_operation = 1'b0;
    logic signed [VALUE_W-1:0] i_value     = '0;
    logic [LEVEL_IN_W-1:0]     i_level     = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [1:0]                o_status;
    logic signed [VALUE_W-1:0] o_out_value;
    logic [LEVEL_OUT_W-1:0]    o_out_level;
    logic                      psel        = 1'b0;
    logic                      penable     = 1'b0;
    logic                      pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0]     paddr       = '0;
    logic [APB_DATA_W-1:0]     pwdata      = '0;
    logic [APB_DATA_W-1:0]     prdata;
    logic                      pready;

    // scoreboard copy of the queue
    logic [CFG_LEVELS_W-1:0] level_limit = LEVELS_RESET;
    logic [VALUE_W-1:0]      word_mem [NUM_LEVELS][FIFO_DEPTH];
    int                      rd_ptr   [NUM_LEVELS] = '{default: 0};
    int                      wr_ptr   [NUM_LEVELS] = '{default: 0};
    int                      fill_cnt [NUM_LEVELS] = '{default: 0};

    t_pq_cmd    cmd_backlog[$];
    t_pq_result predicted[$];
    t_pq_cmd    driven_cmd;
    t_pq_result head_exp;

    int error_count   = 0;
    int send_idle_pct = 25;
    int recv_idle_pct = 78;
    int hold_left     = 0;
    logic hold_arm    = 1'b0;
    int stall_cycles  = 0;

    multi_level_priority_queue u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic flag_error(input string what);
        error_count++;
        if (error_count <= 10) begin
            $display("ERROR @%0t: %s", $time, what);
        end
    endtask

    function automatic t_pq_result pq_apply(input t_pq_cmd cmd);
        t_pq_result res;
        int active;
        int lv;
        res.status = ST_OK;
        res.value  = '0;
        res.level  = '0;
        active = (level_limit > NUM_LEVELS) ? NUM_LEVELS : int'(level_limit);
        if (cmd.op == OP_ENQUEUE) begin
            if (int'(cmd.level) >= active) begin
                res.status = ST_RANGE;
            end else if (fill_cnt[cmd.level] >= FIFO_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                word_mem[cmd.level][wr_ptr[cmd.level]] = cmd.value;
                wr_ptr[cmd.level] = (wr_ptr[cmd.level] + 1) % FIFO_DEPTH;
                fill_cnt[cmd.level]++;
            end
        end else begin
            res.status = ST_EMPTY;
            for (lv = 0; lv < active; lv++) begin
                if (res.status == ST_EMPTY && fill_cnt[lv] != 0) begin
                    res.status = ST_OK;
                    res.value  = word_mem[lv][rd_ptr[lv]];
                    res.level  = LEVEL_OUT_W'(lv);
                    rd_ptr[lv] = (rd_ptr[lv] + 1) % FIFO_DEPTH;
                    fill_cnt[lv]--;
                end
            end
        end
        return res;
    endfunction

    // input channel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predicted.push_back(pq_apply(driven_cmd));
            end
            if (!i_in_valid || o_in_ready) begin
                if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    driven_cmd = cmd_backlog.pop_front();
                    i_in_valid  <= 1'b1;
                    i_operation <= driven_cmd.op;
                    i_value     <= driven_cmd.value;
                    i_level     <= driven_cmd.level;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result channel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (predicted.size() == 0) begin
                    flag_error($sformatf("unexpected result status %0d value %h level %0d",
                                         o_status, o_out_value, o_out_level));
                end else begin
                    head_exp = predicted.pop_front();
                    if (o_status !== head_exp.status || o_out_value !== head_exp.value ||
                        o_out_level !== head_exp.level) begin
                        flag_error($sformatf({"status exp %0d got %0d, value exp %h got %h, ",
                                              "level exp %0d got %0d"},
                                             head_exp.status, o_status, head_exp.value,
                                             o_out_value, head_exp.level, o_out_level));
                    end
                end
            end
            i_out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_arm) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_cmd(input t_op op, input logic [VALUE_W-1:0] value,
                             input logic [LEVEL_IN_W-1:0] level);
        t_pq_cmd cmd;
        cmd.op    = op;
        cmd.value = value;
        cmd.level = level;
        cmd_backlog.push_back(cmd);
    endtask

    task automatic wait_idle();
        while (cmd_backlog.size() != 0 || i_in_valid || predicted.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic apb_cycle(input logic wr, input t_reg_idx idx,
                             input logic [APB_DATA_W-1:0] data,
                             output logic [APB_DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_W'(int'(idx) * 4);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_write(input t_reg_idx idx, input logic [APB_DATA_W-1:0] data);
        logic [APB_DATA_W-1:0] rdata;
        wait_idle();
        apb_cycle(1'b1, idx, data, rdata);
        if (idx == REG_LEVELS_IN_USE) begin
            level_limit = data[CFG_LEVELS_W-1:0];
        end
        apb_cycle(1'b0, REG_LEVELS_IN_USE, '0, rdata);
        if (rdata[CFG_LEVELS_W-1:0] !== level_limit) begin
            flag_error($sformatf("levels_in_use readback exp %0d got %0d",
                                 level_limit, rdata[CFG_LEVELS_W-1:0]));
        end
    endtask

    task automatic random_segment(input int n_items);
        int active;
        int left;
        int burst;
        int enq_pct;
        int k;
        t_op op;
        logic [VALUE_W-1:0] value;
        logic [LEVEL_IN_W-1:0] level;
        active = (level_limit > NUM_LEVELS) ? NUM_LEVELS : int'(level_limit);
        left = n_items;
        while (left > 0) begin
            burst = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
                0: begin
                    enq_pct = 85;
                end
                1: begin
                    enq_pct = 15;
                end
                default: begin
                    enq_pct = 50;
                end
            endcase
            for (k = 0; k < burst && left > 0; k++) begin
                op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
                case ($urandom_range(0, 9))
                    0: begin
                        value = 32'h7FFF_FFFF;
                    end
                    1: begin
                        value = 32'h8000_0000;
                    end
                    default: begin
                        value = $urandom;
                    end
                endcase
                if (active != 0 && $urandom_range(0, 99) < 85) begin
                    level = LEVEL_IN_W'($urandom_range(0, active - 1));
                end else begin
                    level = LEVEL_IN_W'($urandom_range(0, 7));
                end
                queue_cmd(op, value, level);
                left--;
            end
        end
    endtask

    initial begin
        int phase;
        int seg;
        int i;
        int send_plan[3];
        int recv_plan[3];
        logic [CFG_LEVELS_W-1:0] level_plan[8];
        send_plan  = '{25, 78, 0};
        recv_plan  = '{78, 25, 0};
        level_plan = '{3'd4, 3'd1, 3'd7, 3'd3, 3'd0, 3'd2, 3'd6, 3'd5};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_cmd(OP_DEQUEUE, 32'h0, 3'd0);
        queue_cmd(OP_ENQUEUE, 32'h7FFF_FFFF, 3'd3);
        queue_cmd(OP_ENQUEUE, 32'h8000_0000, 3'd0);
        queue_cmd(OP_ENQUEUE, 32'hFFFF_FFFF, 3'd1);
        queue_cmd(OP_ENQUEUE, 32'h0000_0000, 3'd2);
        queue_cmd(OP_ENQUEUE, 32'h1234_5678, 3'd4);
        queue_cmd(OP_ENQUEUE, 32'hDEAD_BEEF, 3'd7);
        repeat (4) queue_cmd(OP_DEQUEUE, 32'hFFFF_FFFF, 3'd7);
        queue_cmd(OP_ENQUEUE, 32'h5A5A_A5A5, 3'd3);
        // hide level 3, then expose it again
        cfg_write(REG_LEVELS_IN_USE, 32'd2);
        queue_cmd(OP_DEQUEUE, 32'h0, 3'd0);
        cfg_write(REG_LEVELS_IN_USE, 32'd0);
        queue_cmd(OP_ENQUEUE, 32'h1, 3'd0);
        queue_cmd(OP_DEQUEUE, 32'h0, 3'd0);
        cfg_write(REG_LEVELS_IN_USE, 32'd7);
        queue_cmd(OP_ENQUEUE, 32'h2, 3'd4);
        queue_cmd(OP_DEQUEUE, 32'h0, 3'd0);
        cfg_write(REG_UNUSED, 32'd1);
        cfg_write(REG_LEVELS_IN_USE, 32'd4);
        for (i = 0; i <= FIFO_DEPTH; i++) begin
            queue_cmd(OP_ENQUEUE, $urandom, 3'd1);
        end

        for (phase = 0; phase < 3; phase++) begin
            wait_idle();
            send_idle_pct <= send_plan[phase];
            recv_idle_pct <= recv_plan[phase];
            cfg_write(REG_UNUSED, $urandom);
            for (seg = 0; seg < SEG_COUNT; seg++) begin
                cfg_write(REG_LEVELS_IN_USE, 32'(level_plan[(phase * SEG_COUNT + seg) % 8]));
                if (phase == 2 && seg == 1) begin
                    // stall the receiver while the sender keeps pushing
                    hold_arm <= 1'b1;
                    @(posedge i_clk);
                    hold_arm <= 1'b0;
                end
                random_segment(SEG_ITEMS);
            end
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (predicted.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", predicted.size()));
        end
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/mlpq_pkg.sv
hw/rtl/mlpq_ram.sv
hw/rtl/multi_level_priority_queue.sv
hw/rtl/mlpq_checker.sv
verif/testbench.sv
